// ----- design/vcu_pkg.sv -----
// Shared types, constants and helpers for the vector clock unit.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package vcu_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int COUNTER_BITS  = 32;
   localparam int RESULT_LIMIT  = 16;
   localparam int SLOT_BITS     = $clog2(MAX_PROCESSES);
   localparam int SLOT_LIMIT    = (MAX_PROCESSES < RESULT_LIMIT) ? MAX_PROCESSES
                                                                 : RESULT_LIMIT;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] COUNTER_MAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNTER_BITS);

   typedef logic [COUNTER_BITS-1:0] counter_type;
   localparam counter_type COUNTER_MAX = COUNTER_MAX64[COUNTER_BITS-1:0];

   // event kinds
   localparam logic [1:0] FUNC_INTERNAL = 2'd0;
   localparam logic [1:0] FUNC_SEND     = 2'd1;
   localparam logic [1:0] FUNC_RECEIVE  = 2'd2;

   // register indexes
   localparam logic CSR_OWN_SLOT      = 1'b0;
   localparam logic CSR_PROCESS_COUNT = 1'b1;

   typedef struct packed {
      logic        merge;    // fold element into slot by maximum
      logic        finish;   // bump own counter and emit the vector
      logic [3:0]  slot;
      counter_type element;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_BUMP_RD,
      ST_BUMP_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } back_state_type;

   // number of vector slots in use, 1..SLOT_LIMIT
   function automatic logic [4:0] slots_in_use(input logic [4:0] process_count);
      logic [4:0] c;
      c = (process_count == 5'd0) ? 5'd1 : process_count;
      if (32'(c) > SLOT_LIMIT) c = 5'(SLOT_LIMIT);
      return c;
   endfunction

   function automatic counter_type sat_element(input logic [31:0] e);
      logic [63:0] w;
      w = {32'd0, e};
      if (w > COUNTER_MAX64) return COUNTER_MAX;
      return w[COUNTER_BITS-1:0];
   endfunction

   function automatic logic [31:0] low_word(input counter_type c);
      logic [63:0] w;
      w = 64'(c);
      return w[31:0];
   endfunction

endpackage

// ----- design/vcu_front.sv -----
// Front end: accepts request transfers, tracks the receive position of an
// incoming clock and turns each merging or finishing item into a back-end command. Uses vcu_pkg.
`timescale 1ns / 1ps

module vcu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [31:0]      req_clock_element,
   input  logic             req_element_last,
   input  logic [4:0]       slot_count,
   input  logic             queue_full,
   output logic             push,
   output vcu_pkg::cmd_type push_cmd
);

   logic [3:0] pos_ff, pos_in;
   logic       full_ff, full_in;
   logic       accept, is_event, is_recv, room;
   logic [4:0] pos_next;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_event  = (req_func == vcu_pkg::FUNC_INTERNAL) || (req_func == vcu_pkg::FUNC_SEND);
   assign is_recv   = (req_func == vcu_pkg::FUNC_RECEIVE);
   assign room      = !full_ff && ({1'b0, pos_ff} < slot_count);
   assign pos_next  = {1'b0, pos_ff} + 5'd1;

   always_comb begin
      push_cmd.merge   = is_recv && room;
      push_cmd.finish  = is_event || (is_recv && req_element_last);
      push_cmd.slot    = pos_ff;
      push_cmd.element = vcu_pkg::sat_element(req_clock_element);
   end

   assign push = accept && (push_cmd.merge || push_cmd.finish);

   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (accept && is_recv) begin
         if (req_element_last) begin
            pos_in  = 4'd0;
            full_in = 1'b0;
         end else if (room) begin
            if (pos_next >= slot_count) begin
               full_in = 1'b1;
            end else begin
               pos_in = pos_next[3:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd0;
         full_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         full_ff <= full_in;
      end
   end

endmodule

// ----- design/vcu_queue.sv -----
// Short command queue between the front end and the back end.
// Uses vcu_pkg for the command type and depth.
`timescale 1ns / 1ps

module vcu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vcu_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output vcu_pkg::cmd_type pop_cmd
);

   vcu_pkg::cmd_type                   entry_ff [vcu_pkg::QUEUE_DEPTH];
   logic [vcu_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [vcu_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [vcu_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   logic                               do_push, do_pop;

   assign full      = (32'(count_ff) == vcu_pkg::QUEUE_DEPTH);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == vcu_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == vcu_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/vcu_back.sv -----
// Back end: holds the counter store, merges elements, bumps the own counter
// and streams the vector out through a result register. Uses vcu_pkg.
`timescale 1ns / 1ps

module vcu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  vcu_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic [3:0]       own_slot,
   input  logic [4:0]       slot_count,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [3:0]       rsp_slot_index,
   output logic [31:0]      rsp_counter_value,
   output logic             rsp_run_last
);

   vcu_pkg::back_state_type state_ff, state_in;
   vcu_pkg::cmd_type        cmd_ff, cmd_in;
   logic [3:0]              slot_ff, slot_in;

   // counter store; entries not yet written read as zero
   vcu_pkg::counter_type            mem [vcu_pkg::MAX_PROCESSES];
   logic [vcu_pkg::MAX_PROCESSES-1:0] written_ff;
   vcu_pkg::counter_type            rd_data_ff;
   logic                            rd_written_ff;
   vcu_pkg::counter_type            cur;

   logic                            rd_en, wr_en, load_out, out_free, own_ok, emit_last;
   logic [vcu_pkg::SLOT_BITS-1:0]   rd_addr, wr_addr;
   vcu_pkg::counter_type            wr_data;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [3:0]                      rsp_slot_ff;
   logic [31:0]                     rsp_value_ff;
   logic                            rsp_last_ff;

   assign cur       = rd_written_ff ? rd_data_ff : '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign own_ok    = (32'(own_slot) < vcu_pkg::MAX_PROCESSES);
   assign emit_last = (({1'b0, slot_ff} + 5'd1) == slot_count);

   // next state
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      case (state_ff)
         vcu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = cmd.merge ? vcu_pkg::ST_MERGE_RD : vcu_pkg::ST_BUMP_RD;
            end
         end
         vcu_pkg::ST_MERGE_RD: state_in = vcu_pkg::ST_MERGE_WR;
         vcu_pkg::ST_MERGE_WR: begin
            state_in = cmd_ff.finish ? vcu_pkg::ST_BUMP_RD : vcu_pkg::ST_IDLE;
         end
         vcu_pkg::ST_BUMP_RD: begin
            slot_in  = 4'd0;
            state_in = own_ok ? vcu_pkg::ST_BUMP_WR : vcu_pkg::ST_EMIT_RD;
         end
         vcu_pkg::ST_BUMP_WR: begin
            slot_in  = 4'd0;
            state_in = vcu_pkg::ST_EMIT_RD;
         end
         vcu_pkg::ST_EMIT_RD: begin
            if (out_free) state_in = vcu_pkg::ST_EMIT_LD;
         end
         vcu_pkg::ST_EMIT_LD: begin
            if (emit_last) begin
               state_in = vcu_pkg::ST_IDLE;
            end else begin
               slot_in  = slot_ff + 4'd1;
               state_in = vcu_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = vcu_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      cmd_pop  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = cur;
      load_out = 1'b0;
      case (state_ff)
         vcu_pkg::ST_IDLE: cmd_pop = cmd_valid;
         vcu_pkg::ST_MERGE_RD: begin
            rd_en   = 1'b1;
            rd_addr = vcu_pkg::SLOT_BITS'(cmd_ff.slot);
         end
         vcu_pkg::ST_MERGE_WR: begin
            wr_addr = vcu_pkg::SLOT_BITS'(cmd_ff.slot);
            wr_en   = (cmd_ff.element > cur);
            wr_data = cmd_ff.element;
         end
         vcu_pkg::ST_BUMP_RD: begin
            rd_en   = own_ok;
            rd_addr = vcu_pkg::SLOT_BITS'(own_slot);
         end
         vcu_pkg::ST_BUMP_WR: begin
            wr_addr = vcu_pkg::SLOT_BITS'(own_slot);
            wr_en   = (cur != vcu_pkg::COUNTER_MAX);
            wr_data = cur + 1'b1;
         end
         vcu_pkg::ST_EMIT_RD: begin
            rd_en   = out_free;
            rd_addr = vcu_pkg::SLOT_BITS'(slot_ff);
         end
         vcu_pkg::ST_EMIT_LD: load_out = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vcu_pkg::ST_IDLE;
         slot_ff      <= 4'd0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_data_ff    <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
      if (load_out) begin
         rsp_slot_ff  <= slot_ff;
         rsp_value_ff <= vcu_pkg::low_word(cur);
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_counter_value = rsp_value_ff;
   assign rsp_run_last      = rsp_last_ff;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !rsp_valid_ff)
      else $error("result register overwritten");

   a_no_write_while_emit: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !wr_en)
      else $error("store written during emit");

   a_merge_follows_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == vcu_pkg::ST_MERGE_WR |-> $past(state_ff) == vcu_pkg::ST_MERGE_RD)
      else $error("merge write without read");

   a_last_on_final_slot: assert property (@(posedge clock) disable iff (reset)
      load_out && emit_last |=> rsp_last_ff && ({1'b0, rsp_slot_ff} + 5'd1 == slot_count))
      else $error("run end on wrong slot");

endmodule

// ----- design/vector_clock_unit_core.sv -----
// Top level of the vector clock unit: configuration registers, front end,
// command queue and back end. Uses vcu_pkg, vcu_front, vcu_queue, vcu_back.
// Sequencing: the back end handles a middle element as pop, read, write; an
//   internal or send transfer, or a closing element after any merge, bumps the
//   own counter, then streams the vector slot by slot through the result register,
//   stalling while it is full. The back end takes one command at a time.
// Reset is synchronous and active high: all counters read zero, the receive
//   position returns to slot 0, own_slot becomes 0 and process_count 16.
`timescale 1ns / 1ps

module vector_clock_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_clock_element,
   input  logic        req_element_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_slot_index,
   output logic [31:0] rsp_counter_value,
   output logic        rsp_run_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [4:0]  csr_write_data
);

   logic [3:0]       own_slot_ff;
   logic [4:0]       process_count_ff;
   logic [4:0]       slot_count;
   logic             push, queue_full, pop, pop_valid;
   vcu_pkg::cmd_type push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_slot_ff      <= 4'd0;
         process_count_ff <= 5'd16;
      end else if (csr_write_enable) begin
         case (csr_index)
            vcu_pkg::CSR_OWN_SLOT:      own_slot_ff      <= csr_write_data[3:0];
            vcu_pkg::CSR_PROCESS_COUNT: process_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign slot_count = vcu_pkg::slots_in_use(process_count_ff);

   vcu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_clock_element (req_clock_element),
      .req_element_last  (req_element_last),
      .slot_count        (slot_count),
      .queue_full        (queue_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   vcu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   vcu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (pop_valid),
      .cmd               (pop_cmd),
      .cmd_pop           (pop),
      .own_slot          (own_slot_ff),
      .slot_count        (slot_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_counter_value (rsp_counter_value),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
